/* rtl/tanh_pkg.sv */
package tanh_pkg;

  localparam int XW       = 16;
  localparam int QW       = 16;
  localparam int RW       = 105;
  localparam int DW       = 90;
  localparam int DIV_BITS = 16;

  localparam logic [15:0] X_LIMIT = 16'd10035;
  localparam logic [14:0] Q_ONE   = 15'd16384;

  localparam logic [30:0] C378   = 31'(378)    << 22;
  localparam logic [33:0] C3150  = 34'(3150)   << 22;
  localparam logic [58:0] C17325 = 59'(17325)  << 44;
  localparam logic [61:0] C62370 = 62'(62370)  << 44;
  localparam logic [88:0] C135K  = 89'(135135) << 66;

  typedef struct packed {
    logic valid;
    logic action;
    logic last;
    logic neg;
    logic zero;
    logic tail;
    logic sat;
  } side_t;

  typedef struct packed {
    side_t          sd;
    logic [RW-1:0]  rem;
    logic [DW-1:0]  den;
    logic [QW-1:0]  q;
  } div_t;

endpackage

/* rtl/tanh_activation_unit.sv */
// tanh_activation_unit: Pade 7/6 tanh and tanh derivative, Q4.11 in, Q1.14 out.
// Throughput: one transaction per cycle unless a stalled output result holds
// the pipe; the 16-step restoring divider is fully unrolled over 16
// registered stages, one quotient bit per stage.
// Reset: rst (synchronous, active high) clears every stage valid bit;
// data registers are not reset.
module tanh_activation_unit
  import tanh_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  x_valid,
  output logic                  x_stall,
  input  logic                  action,
  input  logic signed [XW-1:0]  x_value,
  input  logic                  last_element,
  output logic                  y_valid,
  input  logic                  y_stall,
  output logic signed [15:0]    y_value,
  output logic                  last_out
);

  // Whole pipe advances together; it halts only when the output holds a
  // result that the consumer stalls.
  logic en;
  assign en      = !(y_valid && y_stall);
  assign x_stall = !en;

  // Stage 1: magnitude, range flags, x^2 (scaled by 2^22).
  logic [15:0] mag_in;
  logic [13:0] m_in;
  side_t       sd_in;
  assign mag_in = x_value[15] ? 16'(-x_value) : x_value;
  // saturated samples feed zero into the divider so it stays in range
  assign m_in   = (mag_in >= X_LIMIT) ? '0 : mag_in[13:0];
  always_comb begin
    sd_in.valid  = x_valid;
    sd_in.action = action;
    sd_in.last   = last_element;
    sd_in.neg    = x_value[15];
    sd_in.zero   = (x_value == '0);
    sd_in.tail   = (mag_in > X_LIMIT);
    sd_in.sat    = (mag_in >= X_LIMIT);
  end

  side_t       sd1, sd2, sd3, sd4, sd5;
  logic [13:0] m1, m2, m3, m4;
  logic [26:0] u1, u2;
  always_ff @(posedge clk) begin
    if (rst) begin
      sd1.valid <= 1'b0;
    end else if (en) begin
      sd1 <= sd_in;
      m1  <= m_in;
      u1  <= 27'(m_in) * 27'(m_in);
    end
  end

  // Stage 2: first Horner step of numerator and denominator.
  logic [57:0] p1;
  logic [60:0] dp1;
  always_ff @(posedge clk) begin
    if (rst) begin
      sd2.valid <= 1'b0;
    end else if (en) begin
      sd2 <= sd1;
      m2  <= m1;
      u2  <= u1;
      p1  <= 58'(31'(u1) + C378) * 58'(u1);
      dp1 <= 61'(34'(28) * 34'(u1) + C3150) * 61'(u1);
    end
  end

  // Stage 3: second Horner step as 32-bit partial products.
  logic [58:0] n2;
  logic [61:0] d2;
  logic [58:0] nlo, dlo;
  logic [53:0] nhi;
  logic [56:0] dhi;
  assign n2 = 59'(p1) + C17325;
  assign d2 = 62'(dp1) + C62370;
  always_ff @(posedge clk) begin
    if (rst) begin
      sd3.valid <= 1'b0;
    end else if (en) begin
      sd3 <= sd2;
      m3  <= m2;
      nlo <= 59'(n2[31:0]) * 59'(u2);
      nhi <= 54'(n2[58:32]) * 54'(u2);
      dlo <= 59'(d2[31:0]) * 59'(u2);
      dhi <= 57'(d2[61:32]) * 57'(u2);
    end
  end

  // Stage 4: assemble N and D.
  logic [85:0] nn;
  logic [88:0] dd4;
  always_ff @(posedge clk) begin
    if (rst) begin
      sd4.valid <= 1'b0;
    end else if (en) begin
      sd4 <= sd3;
      m4  <= m3;
      nn  <= 86'(nlo) + (86'(nhi) << 32) + 86'(C135K);
      dd4 <= 89'(dlo) + (89'(dhi) << 32) + C135K;
    end
  end

  // Stage 5: N * 16|x| as three partial products.
  logic [17:0] m16;
  logic [49:0] pp0, pp1;
  logic [39:0] pp2;
  logic [88:0] dd5;
  assign m16 = {m4, 4'b0};
  always_ff @(posedge clk) begin
    if (rst) begin
      sd5.valid <= 1'b0;
    end else if (en) begin
      sd5 <= sd4;
      pp0 <= 50'(nn[31:0]) * 50'(m16);
      pp1 <= 50'(nn[63:32]) * 50'(m16);
      pp2 <= 40'(nn[85:64]) * 40'(m16);
      dd5 <= dd4;
    end
  end

  // Stage 6: rounding setup, quotient = floor((16|X|N + D) / 2D).
  div_t dv [0:DIV_BITS];
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].sd.valid <= 1'b0;
    end else if (en) begin
      dv[0].sd  <= sd5;
      dv[0].rem <= RW'(pp0) + (RW'(pp1) << 32) + (RW'(pp2) << 64) + RW'(dd5);
      dv[0].den <= {dd5, 1'b0};
      dv[0].q   <= '0;
    end
  end

  // Stages 7..22: one restoring divide step per stage, MSB first.
  for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
    localparam int B = DIV_BITS - 1 - i;
    logic [RW-1:0] trial;
    logic          fits;
    assign trial = RW'(dv[i].den) << B;
    assign fits  = (dv[i].rem >= trial);
    always_ff @(posedge clk) begin
      if (rst) begin
        dv[i+1].sd.valid <= 1'b0;
      end else if (en) begin
        dv[i+1].sd  <= dv[i].sd;
        dv[i+1].den <= dv[i].den;
        dv[i+1].rem <= fits ? dv[i].rem - trial : dv[i].rem;
        dv[i+1].q   <= dv[i].q | (fits ? (QW'(1) << B) : '0);
      end
    end
  end

  // Stage 23: clamp, sign, derivative; this is the output register.
  side_t               sdf;
  logic [14:0]         tm;
  logic [29:0]         sq;
  logic signed [15:0]  y_next;
  assign sdf = dv[DIV_BITS].sd;
  always_comb begin
    if (sdf.sat || dv[DIV_BITS].q > QW'(Q_ONE)) begin
      tm = Q_ONE;
    end else begin
      tm = dv[DIV_BITS].q[14:0];
    end
    sq = (30'(tm) * 30'(tm) + 30'(8192)) >> 14;
    if (!sdf.action) begin
      y_next = sdf.neg ? -16'(tm) : 16'(tm);
    end else if (sdf.zero) begin
      y_next = 16'(Q_ONE);
    end else if (sdf.tail) begin
      y_next = '0;
    end else begin
      y_next = 16'(Q_ONE) - sq[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      y_valid <= 1'b0;
    end else if (en) begin
      y_valid  <= sdf.valid;
      y_value  <= y_next;
      last_out <= sdf.last;
    end
  end

  // Result always lies in [-1, +1] in Q1.14.
  a_range: assert property (@(posedge clk) disable iff (rst)
    y_valid |-> (y_value <= 16'sd16384 && y_value >= -16'sd16384))
    else $error("y_value out of range");

  // Divider never leaves a remainder of a full divisor or more.
  a_rem: assert property (@(posedge clk) disable iff (rst)
    dv[DIV_BITS].sd.valid |-> (dv[DIV_BITS].rem < RW'(dv[DIV_BITS].den)))
    else $error("divider remainder too large");

  // A stalled result keeps the pipe frozen, so the output holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (y_valid && y_stall) |=> (y_valid && $stable(y_value) && $stable(last_out)))
    else $error("stalled result changed");

endmodule

/* verif/tanh_scoreboard.sv */
module tanh_scoreboard
  import tanh_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               x_valid,
  input  logic               x_stall,
  input  logic               action,
  input  logic signed [15:0] x_value,
  input  logic               last_element,
  input  logic               y_valid,
  input  logic               y_stall,
  input  logic signed [15:0] y_value,
  input  logic               last_out,
  output int                 fail_count,
  output int                 pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [15:0] y;
    logic               last;
  } act_result_t;

  act_result_t expected_q[$];

  // exact Pade 7/6 tanh, magnitude rounded half away from zero, Q4.11 -> Q1.14
  function automatic logic signed [15:0] pade_tanh(logic signed [15:0] x);
    logic [16:0]  mag;
    logic [127:0] u, num, dnm, quo;
    mag = x < 0 ? 17'(-int'(x)) : 17'(x);
    if (mag >= 17'(X_LIMIT)) return x < 0 ? -16'sd16384 : 16'sd16384;
    u   = 128'(mag) * 128'(mag);
    num = ((u + (128'd378 << 22)) * u + (128'd17325 << 44)) * u + (128'd135135 << 66);
    dnm = ((128'd28 * u + (128'd3150 << 22)) * u + (128'd62370 << 44)) * u
          + (128'd135135 << 66);
    quo = (num * 128'(16 * mag) + dnm) / (dnm << 1);
    if (quo > 128'd16384) quo = 128'd16384;
    return x < 0 ? -16'(quo) : 16'(quo);
  endfunction

  function automatic act_result_t predict_activation(logic act, logic signed [15:0] x,
                                                     logic lst);
    act_result_t r;
    int t, mag, sq;
    mag = x < 0 ? -int'(x) : int'(x);
    r.last = lst;
    if (!act) r.y = pade_tanh(x);
    else if (x == 0) r.y = 16'sd16384;
    else if (mag > int'(X_LIMIT)) r.y = 16'sd0;
    else begin
      t  = int'(pade_tanh(x));
      if (t < 0) t = -t;
      sq = (t * t + 8192) >>> 14;
      r.y = 16'(16384 - sq);
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    act_result_t want;
    if (rst) begin
      fail_count <= 0;
    end else begin
      if (x_valid && !x_stall)
        expected_q.push_back(predict_activation(action, x_value, last_element));
      if (y_valid && !y_stall) begin
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected result y=%0d", y_value);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (want.y !== y_value || want.last !== last_out) begin
            if (fail_count < 10)
              $display("ERROR: y exp %0d got %0d, last exp %0b got %0b",
                       want.y, y_value, want.last, last_out);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* verif/tb_tanh_activation_unit.sv */
module tb_tanh_activation_unit;
  import tanh_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 40;   // pipeline is 23 deep
  localparam int IDLE_LIMIT   = 2000; // cycles with no transaction

  logic               clk = 0;
  logic               rst = 1;
  logic               x_valid = 0, x_stall;
  logic               action = 0;
  logic signed [15:0] x_value = 0;
  logic               last_element = 0;
  logic               y_valid, y_stall = 0;
  logic signed [15:0] y_value;
  logic               last_out;
  int                 fail_count, pending;
  int                 send_idle_pct, recv_idle_pct, quiet_cycles;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  tanh_activation_unit u_top (.*);

  tanh_scoreboard u_sb (.*);

  // receiver: random stall at current phase rate
  always @(posedge clk)
    y_stall <= ($urandom_range(99) < recv_idle_pct);

  // watchdog: count cycles with no accepted transaction on either side
  always @(posedge clk) begin
    if (rst || (x_valid && !x_stall) || (y_valid && !y_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // present one transaction, holding it until accepted; random gap first
  task automatic send_sample(logic act, logic signed [15:0] x, logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      x_valid <= 0;
      @(posedge clk);
    end
    x_valid      <= 1;
    action       <= act;
    x_value      <= x;
    last_element <= lst;
    @(posedge clk);
    while (x_stall) @(posedge clk);
  endtask

  // mostly the interesting range |x| < ~5.5, sometimes the full 16-bit span or near the threshold
  function automatic logic signed [15:0] pick_x();
    case ($urandom_range(9))
      0, 1: return 16'($urandom);
      2:    return 16'(int'($urandom_range(10045, 10025)) * ($urandom_range(1) ? 1 : -1));
      default: return 16'(int'($urandom_range(22000)) - 11000);
    endcase
  endfunction

  logic signed [15:0] corner_x[12] = '{16'sd0, 16'sd1, -16'sd1, 16'sd10034, 16'sd10035,
    16'sd10036, -16'sd10034, -16'sd10035, -16'sd10036, 16'sd32767, -16'sd32768, 16'sd2048};

  initial begin
    send_idle_pct = 30;
    recv_idle_pct = 80;
    repeat (6) @(posedge clk);
    rst <= 0;
    // directed corners: zero, smallest step, threshold edges, field extremes, and 1.0
    foreach (corner_x[i]) begin
      send_sample(1'b0, corner_x[i], i[0]);
      send_sample(1'b1, corner_x[i], !i[0]);
    end
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 80 : 0;
      recv_idle_pct = (ph == 0) ? 80 : (ph == 1) ? 30 : 0;
      repeat (175) send_sample(1'($urandom), pick_x(), ($urandom_range(7) == 0));
    end
    x_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
